>>> rtl/core/bcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_pkg: shared constants and helpers for the Boltzmann cost sampler
// Table of 2^-k/8 in Q1.16, log2(e) in Q.16 and default sizes.
// ----------------------------------------------------------------------------
package bcs_pkg;

    localparam int          DEF_MAX_COSTS = 64;
    localparam int          COST_W        = 32;
    localparam int          ITEMP_W       = 24;
    localparam int          DRAW_W        = 16;
    localparam int          IDX_W         = 6;
    localparam int          WEIGHT_W      = 17;
    localparam logic [23:0] ITEMP_RESET   = 24'd65536;
    localparam logic [16:0] LOG2E_Q16     = 17'd94548;
    localparam logic [31:0] SIGN_FLIP     = 32'h8000_0000;

    function automatic logic [16:0] pow2_frac(input logic [3:0] k);
        logic [16:0] v;
        begin
            unique case (k)
                4'd0:    v = 17'd65536;
                4'd1:    v = 17'd60097;
                4'd2:    v = 17'd55109;
                4'd3:    v = 17'd50535;
                4'd4:    v = 17'd46341;
                4'd5:    v = 17'd42495;
                4'd6:    v = 17'd38968;
                4'd7:    v = 17'd35734;
                default: v = 17'd32768;
            endcase
            return v;
        end
    endfunction

endpackage

>>> rtl/core/boltzmann_cost_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boltzmann_cost_sampler: softmax sampling over a batch of costs
// Loads costs into a store, then weighs and searches them with one draw.
// ----------------------------------------------------------------------------
// A batch is a run of cost beats closed by a beat with last high; that beat
// also carries uniform_draw. Each cost beat is written to a cost memory with
// one write port and one registered read port while the running minimum is
// tracked; costs past MAX_COSTS are dropped. After the last beat the block
// makes two passes over the memory, each streaming N entries through the
// registered read and the weight pipeline: the first sums all weights, the
// second finds the first index whose running sum reaches draw*total. Input is
// stalled during the passes and until the result beat is taken. One result
// beat per batch.
module boltzmann_cost_sampler
    import bcs_pkg::*;
#(
    parameter int MAX_COSTS = DEF_MAX_COSTS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COST_W-1:0]  cost,
    input  logic                      last,
    input  logic [DRAW_W-1:0]         uniform_draw,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [IDX_W-1:0]          chosen_index,
    output logic                      no_pick,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [ITEMP_W-1:0]        cfg_data
);

    localparam int AW = $clog2(MAX_COSTS);
    localparam int CW = $clog2(MAX_COSTS + 1);
    localparam int TW = CW + WEIGHT_W;

    typedef enum logic [1:0] {S_LOAD, S_SUM, S_FIND, S_OUT} state_t;

    state_t              state_reg;
    logic [COST_W-1:0]   mem [MAX_COSTS];
    logic [COST_W-1:0]   rd_reg;
    logic                rd_vld_reg;
    logic [ITEMP_W-1:0]  itemp_reg;
    logic [CW-1:0]       count_reg;
    logic [COST_W-1:0]   min_reg;
    logic [CW-1:0]       rd_ptr_reg;
    logic [CW-1:0]       wt_cnt_reg;
    logic [TW-1:0]       total_reg, cum_reg;
    logic [DRAW_W-1:0]   draw_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    pick_reg;
    logic                busy_reg;
    logic                accept, issue, w_vld;
    logic [COST_W-1:0]   key;
    logic [WEIGHT_W-1:0] w;
    logic [TW-1:0]       cum_next;
    logic [TW+DRAW_W-1:0] target;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_LOAD);
    assign cfg_ready = 1'b1;
    assign key       = cost ^ SIGN_FLIP;
    assign issue     = busy_reg && (rd_ptr_reg < count_reg);
    assign cum_next  = cum_reg + TW'(w);
    assign target    = draw_reg * total_reg;

    // Cost memory: write during load, one registered read per cycle in passes.
    always_ff @(posedge clk)
    begin
        if (accept && count_reg < CW'(MAX_COSTS))
            mem[count_reg[AW-1:0]] <= key;
        rd_reg <= mem[rd_ptr_reg[AW-1:0]] - min_reg;
    end

    bcs_weight u_weight (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (rd_vld_reg),
        .diff     (rd_reg),
        .inv_temp (itemp_reg),
        .out_vld  (w_vld),
        .weight   (w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            itemp_reg  <= ITEMP_RESET;
            count_reg  <= '0;
            min_reg    <= '1;
            rd_ptr_reg <= '0;
            wt_cnt_reg <= '0;
            total_reg  <= '0;
            cum_reg    <= '0;
            found_reg  <= 1'b0;
            pick_reg   <= '0;
            busy_reg   <= 1'b0;
            rd_vld_reg <= 1'b0;
            draw_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                itemp_reg <= cfg_data;
            rd_vld_reg <= issue;
            if (issue)
                rd_ptr_reg <= rd_ptr_reg + CW'(1);
            unique case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (count_reg < CW'(MAX_COSTS))
                        begin
                            count_reg <= count_reg + CW'(1);
                            if (key < min_reg)
                                min_reg <= key;
                        end
                        if (last)
                        begin
                            // hold draw, start sum pass
                            draw_reg   <= uniform_draw;
                            state_reg  <= S_SUM;
                            busy_reg   <= 1'b1;
                            rd_ptr_reg <= '0;
                            wt_cnt_reg <= '0;
                            total_reg  <= '0;
                        end
                    end
                end
                S_SUM:
                begin
                    if (w_vld)
                    begin
                        total_reg  <= total_reg + TW'(w);
                        wt_cnt_reg <= wt_cnt_reg + CW'(1);
                    end
                    if (wt_cnt_reg == count_reg && !rd_vld_reg && !w_vld)
                    begin
                        state_reg  <= S_FIND;
                        rd_ptr_reg <= '0;
                        wt_cnt_reg <= '0;
                        cum_reg    <= '0;
                        found_reg  <= 1'b0;
                        pick_reg   <= '0;
                    end
                end
                S_FIND:
                begin
                    if (w_vld)
                    begin
                        cum_reg    <= cum_next;
                        wt_cnt_reg <= wt_cnt_reg + CW'(1);
                        if (!found_reg && {cum_next, 16'd0} >= target)
                        begin
                            found_reg <= 1'b1;
                            pick_reg  <= IDX_W'(wt_cnt_reg);
                        end
                    end
                    if (wt_cnt_reg == count_reg && !rd_vld_reg && !w_vld)
                    begin
                        state_reg <= S_OUT;
                        busy_reg  <= 1'b0;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        // drop batch
                        state_reg <= S_LOAD;
                        count_reg <= '0;
                        min_reg   <= '1;
                        total_reg <= '0;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign out_valid    = (state_reg == S_OUT);
    assign chosen_index = found_reg ? pick_reg : '0;
    assign no_pick      = !found_reg;

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> in_stall) else $error("input taken during pass");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_COSTS)) else $error("count overflow");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(chosen_index))
        else $error("result dropped");

endmodule

>>> rtl/core/bcs_weight.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_weight: pipelined exp(-d*inv_temp) weight unit
// Four register stages: d*inv_temp, >>16, times log2(e) split in halves, table blend.
// ----------------------------------------------------------------------------
module bcs_weight
    import bcs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  logic [COST_W-1:0]   diff,
    input  logic [ITEMP_W-1:0]  inv_temp,
    output logic                out_vld,
    output logic [WEIGHT_W-1:0] weight
);

    logic [3:0]  vld_reg;
    logic [55:0] x_full_reg;
    logic [39:0] x_reg;
    logic [56:0] y_lo_reg, y_hi_reg;
    logic [57:0] y;
    logic [15:0] f;
    logic [16:0] ta, tb;
    logic [29:0] prod;
    logic [16:0] m;
    logic [WEIGHT_W-1:0] weight_reg;

    // Stage 1: d * inv_temp, 32x24.
    // Stage 2: x = >>16; then y = x*LOG2E split into two 20x17 halves (stage 3).
    assign y = {1'b0, y_hi_reg} + {1'b0, y_lo_reg};
    assign f = y[31:16];
    assign ta = pow2_frac({1'b0, f[15:13]});
    assign tb = pow2_frac({1'b0, f[15:13]} + 4'd1);
    assign prod = (ta - tb) * {4'd0, f[12:0]};
    assign m = ta - 17'(prod >> 13);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        x_full_reg <= diff * inv_temp;
        x_reg      <= x_full_reg[55:16];
        y_lo_reg   <= {20'd0, 37'(x_reg[19:0]) * 37'(LOG2E_Q16)};
        y_hi_reg   <= {37'(x_reg[39:20]) * 37'(LOG2E_Q16), 20'd0};
        if (y[57:32] > 26'd16)
            weight_reg <= '0;
        else
            weight_reg <= m >> y[36:32];
    end

    assign out_vld = vld_reg[3];
    assign weight  = weight_reg;

endmodule
